/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define TCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TCF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/tcf_pkg.sv */
`timescale 1ns / 1ps
package tcf_pkg;
  localparam int SCREEN_COLS  = 128;
  localparam int SCREEN_ROWS  = 160;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int ITER_W       = $clog2(CORDIC_ITERS + 1);

  localparam int CX_W   = 28;
  localparam int CZ_W   = 26;
  localparam int ANG_W  = 18;
  localparam int POS_W  = 12;
  localparam int TONE_W = 11;
  localparam int ACC_W  = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [ANG_W-1:0] ANG_MAX = 18'sd92160;
  localparam logic signed [CZ_W-1:0] Z_HALF_TURN = 26'sd11796480;
  localparam logic [16:0] INV_K = 17'd39797;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  localparam logic [TONE_W-1:0] PERIOD_RESET  = 11'd999;
  localparam logic [TONE_W-1:0] COMPARE_RESET = 11'd500;
  localparam logic [TONE_W-1:0] PERIOD_MID    = 11'd1000;
  localparam logic [TONE_W-1:0] COMPARE_MID   = 11'd500;
  localparam logic [TONE_W-1:0] PERIOD_OUT    = 11'd500;
  localparam logic [TONE_W-1:0] COMPARE_OUT   = 11'd250;

  localparam logic [1:0] ZONE_INNER  = 2'd0;
  localparam logic [1:0] ZONE_MIDDLE = 2'd1;
  localparam logic [1:0] ZONE_OUTER  = 2'd2;
  localparam logic [1:0] ZONE_NONE   = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_GAIN, REG_BLEND_WEIGHT, REG_SENSITIVITY, REG_INNER_W,
    REG_INNER_H, REG_OUTER_W, REG_OUTER_H
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } sample_t;

  typedef struct packed {
    logic        valid;
    sample_t     data;
  } qlink_t;

  typedef struct packed {
    logic [15:0] gyro_gain;
    logic [16:0] blend_weight;
    logic [3:0]  sensitivity;
    logic [7:0]  inner_half_width;
    logic [7:0]  inner_half_height;
    logic [7:0]  outer_half_width;
    logic [7:0]  outer_half_height;
  } cfg_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [CZ_W-1:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0:  atan_q16 = 26'd2949120;
      5'd1:  atan_q16 = 26'd1740967;
      5'd2:  atan_q16 = 26'd919879;
      5'd3:  atan_q16 = 26'd466945;
      5'd4:  atan_q16 = 26'd234379;
      5'd5:  atan_q16 = 26'd117304;
      5'd6:  atan_q16 = 26'd58666;
      5'd7:  atan_q16 = 26'd29335;
      5'd8:  atan_q16 = 26'd14668;
      5'd9:  atan_q16 = 26'd7334;
      5'd10: atan_q16 = 26'd3667;
      5'd11: atan_q16 = 26'd1833;
      5'd12: atan_q16 = 26'd917;
      5'd13: atan_q16 = 26'd458;
      5'd14: atan_q16 = 26'd229;
      5'd15: atan_q16 = 26'd115;
      5'd16: atan_q16 = 26'd57;
      5'd17: atan_q16 = 26'd29;
      5'd18: atan_q16 = 26'd14;
      5'd19: atan_q16 = 26'd7;
      5'd20: atan_q16 = 26'd4;
      5'd21: atan_q16 = 26'd2;
      5'd22: atan_q16 = 26'd1;
      default: atan_q16 = 26'd0;
    endcase
  endfunction
endpackage

/* hdl/tcf_ifs.sv */
`timescale 1ns / 1ps
interface tcf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcf_pkg::CFG_IDX_W-1:0]  index;
  logic [tcf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface tcf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface tcf_result_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] roll_angle;
  logic signed [17:0] pitch_angle;
  logic signed [11:0] marker_col;
  logic signed [11:0] marker_row;
  logic               marker_visible;
  logic signed [11:0] old_col;
  logic signed [11:0] old_row;
  logic [1:0]         zone;
  logic               zone_changed;
  logic [10:0]        tone_period;
  logic [10:0]        tone_compare;
  modport source (output valid, roll_angle, pitch_angle, marker_col, marker_row,
                  marker_visible, old_col, old_row, zone, zone_changed,
                  tone_period, tone_compare, input ready);
  modport sink (input valid, roll_angle, pitch_angle, marker_col, marker_row,
                marker_visible, old_col, old_row, zone, zone_changed,
                tone_period, tone_compare, output ready);
endinterface

/* hdl/tcf_queue.sv */
`timescale 1ns / 1ps
module tcf_queue (
  input  logic            clk,
  input  logic            rst,
  tcf_sample_if.sink      sample,
  output tcf_pkg::qlink_t head,
  input  logic            pop
);
  import tcf_pkg::*;

  sample_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                take;

  assign sample.ready = (count < QCNT_W'(QUEUE_DEPTH));
  assign push = sample.valid && sample.ready;
  assign take = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.data  = slots[rd_ptr];

  // advance pointers, wrap at the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{accel_x: sample.accel_x, accel_y: sample.accel_y,
                        accel_z: sample.accel_z, gyro_x: sample.gyro_x,
                        gyro_y: sample.gyro_y};
    end
  end
endmodule

/* hdl/tcf_cordic.sv */
`timescale 1ns / 1ps
module tcf_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tcf_pkg::CX_W-1:0]     x_in,
  input  logic signed [tcf_pkg::CX_W-1:0]     y_in,
  output logic                                done,
  output logic signed [tcf_pkg::ANG_W-1:0]    angle,
  output logic signed [tcf_pkg::CX_W-1:0]     mag
);
  import tcf_pkg::*;

  typedef enum logic {C_IDLE, C_RUN} cstate_t;

  cstate_t                 state;
  logic signed [CX_W-1:0]  x;
  logic signed [CX_W-1:0]  y;
  logic signed [CZ_W-1:0]  z;
  logic [ITER_W-1:0]       iter;
  logic signed [CX_W-1:0]  xs;
  logic signed [CX_W-1:0]  ys;
  logic signed [CZ_W-1:0]  step_ang;
  logic signed [CZ_W-1:0]  z_round;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign step_ang = signed'(atan_q16(5'(iter)));
  assign z_round = z + 26'sd128;
  assign angle = z_round[CZ_W-1:8];
  assign mag = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == C_RUN) && (iter == ITER_W'(CORDIC_ITERS));
      case (state)
        C_IDLE: begin
          if (start) begin
            // left half plane: rotate by half a turn first
            if (x_in < 0) begin
              x <= -x_in;
              y <= -y_in;
              z <= (y_in >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
            end else begin
              x <= x_in;
              y <= y_in;
              z <= '0;
            end
            iter  <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (iter == ITER_W'(CORDIC_ITERS)) begin
            state <= C_IDLE;
          end else begin
            if (y >= 0) begin
              x <= x + ys;
              y <= y - xs;
              z <= z + step_ang;
            end else begin
              x <= x - ys;
              y <= y + xs;
              z <= z - step_ang;
            end
            iter <= iter + 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule

/* hdl/tcf_back.sv */
`timescale 1ns / 1ps
module tcf_back (
  input  logic            clk,
  input  logic            rst,
  input  tcf_pkg::qlink_t head,
  output logic            pop,
  input  tcf_pkg::cfg_t   cfg,
  tcf_result_if.source    result
);
  import tcf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROLL_WAIT, S_MAG, S_SCALE, S_PITCH_WAIT, S_MUL, S_ACC, S_AXIS,
    S_MARK, S_OUT
  } bstate_t;

  typedef enum logic [2:0] {OP_RATE, OP_W_HI, OP_W_LO, OP_W_ANG, OP_ACC} op_t;

  bstate_t                   state;
  op_t                       op;
  logic                      axis;
  sample_t                   smp;
  logic                      c_start;
  logic signed [CX_W-1:0]    c_x;
  logic signed [CX_W-1:0]    c_y;
  logic                      c_done;
  logic signed [ANG_W-1:0]   c_angle;
  logic signed [CX_W-1:0]    c_mag;
  logic signed [ANG_W-1:0]   roll_acc;
  logic signed [ANG_W-1:0]   pitch_acc;
  logic signed [CX_W-1:0]    mag;
  logic signed [CX_W+17:0]   r_prod;
  logic signed [35:0]        prod;
  logic signed [32:0]        p1;
  logic signed [ACC_W-1:0]   t;
  logic signed [ANG_W-1:0]   roll_state;
  logic signed [ANG_W-1:0]   pitch_state;
  logic signed [POS_W-1:0]   col;
  logic signed [POS_W-1:0]   row;
  logic signed [POS_W-1:0]   last_col;
  logic signed [POS_W-1:0]   last_row;
  logic [1:0]                last_zone;
  logic [TONE_W-1:0]         period_reg;
  logic [TONE_W-1:0]         compare_reg;

  logic [16:0]               w;
  logic signed [15:0]        gyro;
  logic signed [ANG_W-1:0]   ang;
  logic signed [ANG_W-1:0]   acc;
  logic signed [17:0]        mul_a;
  logic signed [17:0]        mul_b;
  logic signed [ACC_W-1:0]   t_round;
  logic signed [23:0]        blend_q8;
  logic signed [ANG_W-1:0]   blend_sat;
  logic signed [POS_W-1:0]   col_next;
  logic signed [POS_W-1:0]   row_next;
  logic                      visible;
  logic [12:0]               dx;
  logic [12:0]               dy;
  logic [1:0]                zone_next;
  logic                      changed;
  logic [TONE_W-1:0]         period_next;
  logic [TONE_W-1:0]         compare_next;
  logic                      out_free;

  tcf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .x_in  (c_x),
    .y_in  (c_y),
    .done  (c_done),
    .angle (c_angle),
    .mag   (c_mag)
  );

  assign pop = (state == S_IDLE) && head.valid;
  assign out_free = !result.valid || result.ready;

  // blend operands
  always_comb begin
    w    = (cfg.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.blend_weight;
    gyro = axis ? smp.gyro_y : smp.gyro_x;
    ang  = axis ? pitch_state : roll_state;
    acc  = axis ? pitch_acc : roll_acc;
    case (op)
      OP_RATE: begin
        mul_a = 18'(gyro);
        mul_b = signed'({2'b00, cfg.gyro_gain});
      end
      OP_W_HI: begin
        mul_a = signed'({1'b0, w});
        mul_b = 18'(signed'(p1[32:16]));
      end
      OP_W_LO: begin
        mul_a = signed'({1'b0, w});
        mul_b = signed'({2'b00, p1[15:0]});
      end
      OP_W_ANG: begin
        mul_a = signed'({1'b0, w});
        mul_b = ang;
      end
      OP_ACC: begin
        mul_a = signed'({1'b0, WEIGHT_ONE}) - signed'({1'b0, w});
        mul_b = acc;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    t_round  = t + (ACC_W'(1) <<< 31);
    blend_q8 = t_round[55:32];
    if (blend_q8 > 24'(ANG_MAX)) begin
      blend_sat = ANG_MAX;
    end else if (blend_q8 < -24'(ANG_MAX)) begin
      blend_sat = -ANG_MAX;
    end else begin
      blend_sat = blend_q8[ANG_W-1:0];
    end
  end

  // marker mapping, truncate toward zero, saturate
  function automatic logic signed [POS_W-1:0] to_marker(input int centre,
                                                        input logic signed [ANG_W-1:0] a,
                                                        input logic [3:0] sens);
    logic signed [23:0] tc;
    logic signed [23:0] tq;
    tc = 24'(centre) * 24'sd256
       + 24'(a) * 24'(signed'({1'b0, sens}));
    tq = (tc + ((tc < 0) ? 24'sd255 : 24'sd0)) >>> 8;
    if (tq > 24'sd2047) begin
      to_marker = 12'sd2047;
    end else if (tq < -24'sd2048) begin
      to_marker = -12'sd2048;
    end else begin
      to_marker = tq[POS_W-1:0];
    end
  endfunction

  always_comb begin
    col_next = to_marker(SCREEN_COLS / 2, pitch_state, cfg.sensitivity);
    row_next = to_marker(SCREEN_ROWS / 2, roll_state, cfg.sensitivity);
  end

  // zone and tone
  always_comb begin
    logic signed [12:0] ddx;
    logic signed [12:0] ddy;
    ddx = 13'(col) - 13'sd0 - 13'(SCREEN_COLS / 2);
    ddy = 13'(row) - 13'(SCREEN_ROWS / 2);
    dx = (ddx < 0) ? 13'(-ddx) : 13'(ddx);
    dy = (ddy < 0) ? 13'(-ddy) : 13'(ddy);
    visible = (col >= 0) && (13'(col) < 13'(SCREEN_COLS))
           && (row >= 0) && (13'(row) < 13'(SCREEN_ROWS));
    if (dx < {5'b0, cfg.inner_half_width} && dy < {5'b0, cfg.inner_half_height}) begin
      zone_next = ZONE_INNER;
    end else if (dx < {5'b0, cfg.outer_half_width}
              && dy < {5'b0, cfg.outer_half_height}) begin
      zone_next = ZONE_MIDDLE;
    end else begin
      zone_next = ZONE_OUTER;
    end
    changed = (zone_next != last_zone);
    period_next  = period_reg;
    compare_next = compare_reg;
    if (changed) begin
      case (zone_next)
        ZONE_MIDDLE: begin
          period_next  = PERIOD_MID;
          compare_next = COMPARE_MID;
        end
        ZONE_OUTER: begin
          period_next  = PERIOD_OUT;
          compare_next = COMPARE_OUT;
        end
        default: compare_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      c_start      <= 1'b0;
      result.valid <= 1'b0;
      roll_state   <= '0;
      pitch_state  <= '0;
      last_col     <= POS_W'(SCREEN_COLS / 2);
      last_row     <= POS_W'(SCREEN_ROWS / 2);
      last_zone    <= ZONE_NONE;
      period_reg   <= PERIOD_RESET;
      compare_reg  <= COMPARE_RESET;
      op           <= OP_RATE;
      axis         <= 1'b0;
    end else begin
      c_start <= ((state == S_IDLE) && head.valid) || (state == S_SCALE);
      if ((state == S_OUT) && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            smp     <= head.data;
            c_x     <= CX_W'(head.data.accel_z) <<< 8;
            c_y     <= CX_W'(head.data.accel_y) <<< 8;
            state   <= S_ROLL_WAIT;
          end
        end
        S_ROLL_WAIT: begin
          if (c_done) begin
            roll_acc <= c_angle;
            mag      <= c_mag;
            state    <= S_MAG;
          end
        end
        S_MAG: begin
          r_prod <= mag * signed'({1'b0, INV_K});
          state  <= S_SCALE;
        end
        S_SCALE: begin
          c_x     <= r_prod[CX_W+15:16];
          c_y     <= -(CX_W'(smp.accel_x) <<< 8);
          state   <= S_PITCH_WAIT;
        end
        S_PITCH_WAIT: begin
          if (c_done) begin
            pitch_acc <= c_angle;
            op        <= OP_RATE;
            axis      <= 1'b0;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_ACC;
        end
        S_ACC: begin
          case (op)
            OP_RATE: begin
              p1 <= prod[32:0];
              t  <= '0;
              op <= OP_W_HI;
            end
            OP_W_HI: begin
              t  <= t + (ACC_W'(prod) <<< 16);
              op <= OP_W_LO;
            end
            OP_W_LO: begin
              t  <= t + ACC_W'(prod);
              op <= OP_W_ANG;
            end
            OP_W_ANG: begin
              t  <= t + (ACC_W'(prod) <<< 16);
              op <= OP_ACC;
            end
            default: begin
              t  <= t + (ACC_W'(prod) <<< 16);
              op <= OP_RATE;
            end
          endcase
          state <= (op == OP_ACC) ? S_AXIS : S_MUL;
        end
        S_AXIS: begin
          if (!axis) begin
            roll_state <= blend_sat;
            axis       <= 1'b1;
            state      <= S_MUL;
          end else begin
            pitch_state <= blend_sat;
            state       <= S_MARK;
          end
        end
        S_MARK: begin
          col   <= col_next;
          row   <= row_next;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            result.roll_angle     <= roll_state;
            result.pitch_angle    <= pitch_state;
            result.marker_col     <= col;
            result.marker_row     <= row;
            result.marker_visible <= visible;
            result.old_col        <= last_col;
            result.old_row        <= last_row;
            result.zone           <= zone_next;
            result.zone_changed   <= changed;
            result.tone_period    <= period_next;
            result.tone_compare   <= compare_next;
            period_reg            <= period_next;
            compare_reg           <= compare_next;
            last_zone             <= zone_next;
            last_col              <= col;
            last_row              <= row;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/tilt_complementary_filter_zone.sv */
// Tilt estimator with marker and zone output. Each sample item (three
// accelerometer axes, two gyro axes) yields exactly one result item: the
// roll and pitch angles in Q9.8 degrees from a complementary filter that
// blends gyro-integrated angles with accelerometer tilt from an iterative
// CORDIC, the new and previous marker positions about the screen centre,
// an on-screen flag, the zone, a zone-change flag and the buzzer period and
// compare values. Items are processed one at a time, through the single CORDIC
// unit that runs twice per item (roll, then pitch from the roll magnitude) and
// the one 18x18 multiplier that forms the ten filter products; a result that
// is not taken stalls the core for as long as it waits. A two-entry queue takes
// samples while the core works, and the result register holds a finished item
// while the next one runs. Configuration writes are always accepted and
// must only occur when idle; writes to an index past the register list
// are dropped.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tilt_complementary_filter_zone (
  input  logic          clk,
  input  logic          rst,
  tcf_cfg_if.sink       cfg,
  tcf_sample_if.sink    sample,
  tcf_result_if.source  result
);
  import tcf_pkg::*;

  cfg_t   cfg_regs;
  qlink_t head;
  logic   pop;

  assign cfg.ready = 1'b1;

  // register file; hold values, take a write on the handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.gyro_gain         <= 16'd1281;
      cfg_regs.blend_weight      <= 17'd64225;
      cfg_regs.sensitivity       <= 4'd3;
      cfg_regs.inner_half_width  <= 8'd20;
      cfg_regs.inner_half_height <= 8'd25;
      cfg_regs.outer_half_width  <= 8'd40;
      cfg_regs.outer_half_height <= 8'd50;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GYRO_GAIN:    cfg_regs.gyro_gain         <= cfg.data[15:0];
        REG_BLEND_WEIGHT: cfg_regs.blend_weight      <= cfg.data;
        REG_SENSITIVITY:  cfg_regs.sensitivity       <= cfg.data[3:0];
        REG_INNER_W:      cfg_regs.inner_half_width  <= cfg.data[7:0];
        REG_INNER_H:      cfg_regs.inner_half_height <= cfg.data[7:0];
        REG_OUTER_W:      cfg_regs.outer_half_width  <= cfg.data[7:0];
        REG_OUTER_H:      cfg_regs.outer_half_height <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // front: buffer raw samples
  tcf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .head   (head),
    .pop    (pop)
  );

  // back: CORDIC, filter, marker, zone and tone
  tcf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .cfg    (cfg_regs),
    .result (result)
  );

  `TCF_ASSERT(a_zone_set, result.valid |-> result.zone != ZONE_NONE,
              "result zone unset")
  `TCF_ASSERT(a_roll_range,
              result.valid |-> (result.roll_angle <= ANG_MAX && result.roll_angle >= -ANG_MAX),
              "roll out of range")
  `TCF_ASSERT(a_visible,
              (result.valid && result.marker_visible)
                |-> (result.marker_col >= 0 && result.marker_row >= 0),
              "visible marker off screen")
  `TCF_ASSERT_ALWAYS(a_pop_head, pop |-> head.valid, "pop from empty queue")
endmodule
